FILE: sv/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg: shared constants for the signed decimal text formatter
// ASCII codes and BCD correction values used by the block and its checker.
// ----------------------------------------------------------------------------
package sida_pkg;

    // ASCII codes of the characters the block can emit.
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Shift-add-3 correction: a BCD digit of five or more gets three added
    // before the next left shift.
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

FILE: sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's-complement integer to its decimal text, most significant
// digit first, with a leading '-' for negative values and the last character
// marked.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  -------   ---------  -----------------  ------------------------------
//  input     in         i_valid / o_stall  i_value (VALUE_WIDTH, signed)
//  output    out        o_valid / i_stall  o_char_code (8), o_last_char
//
// One input word is accepted in idle, then converted with one shift-add-3
// step per magnitude bit in a single shared BCD adjust/shift unit. Leading
// zeros are then dropped one per cycle, the zero skip is left, a '-' is
// emitted for a negative value, and the remaining digits are emitted one per
// cycle while the output does not stall. Output stalls hold the character
// register and pause the sequencer only while it emits the sign or a digit.
// Reset is synchronous and active low; it returns the sequencer to idle and
// empties the output register. The block takes a new word once the last
// character of the previous word sits in the output register.

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    // Output channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_char_code,
    output logic                          o_last_char
);

    // Decimal digits needed for a VALUE_WIDTH-bit magnitude.
    localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam int LEFT_W = $clog2(DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [LEFT_W-1:0]      r_left, n_left;
    logic                   r_neg, n_neg;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    logic                   w_accept;
    logic                   w_slot;
    logic [BCD_W-1:0]       w_bcd_adj;
    logic [3:0]             w_top;

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last_char = r_out_last;

    assign w_accept = i_valid && (r_state == S_IDLE);
    // The output register can take a character this cycle.
    assign w_slot   = !r_out_valid || !i_stall;
    assign w_top    = r_bcd[BCD_W-1 -: 4];

    // Shared unit: add three to every BCD digit of five or more.
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= sida_pkg::BCD_ADJ_MIN) begin
                w_bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + sida_pkg::BCD_ADJ_ADD;
            end else begin
                w_bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    // Sequencer next-state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_count     = r_count;
        n_left      = r_left;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = i_value[VALUE_WIDTH-1];
                    // The magnitude is unsigned, so the most negative value
                    // comes out right.
                    n_mag   = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_count = '0;
                    n_left  = LEFT_W'(DIGITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                // One shift-add-3 step per magnitude bit, MSB first.
                n_bcd   = {w_bcd_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                n_mag   = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_count = r_count + 1'b1;
                if (r_count == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // Drop leading zeros, but always keep the units digit.
                if ((w_top == 4'd0) && (r_left > LEFT_W'(1))) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - 1'b1;
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sida_pkg::ASCII_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sida_pkg::ASCII_ZERO + {4'd0, w_top};
                    n_out_last  = (r_left == LEFT_W'(1));
                    n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left      = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mag      <= n_mag;
        r_bcd      <= n_bcd;
        r_count    <= n_count;
        r_left     <= n_left;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

FILE: sv/sida_checker.sv
// ----------------------------------------------------------------------------
// sida_checker: port-level checks for the decimal text formatter
// Watches the handshakes and character stream at the block boundary.
// ----------------------------------------------------------------------------
module sida_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_char_code,
    input logic       o_last_char
);

    // A stalled output word holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_char_code) && $stable(o_last_char)))
        else $error("stalled output word changed");

    // Only '-' or a decimal digit ever appears.
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_code == sida_pkg::ASCII_MINUS) ||
                     ((o_char_code >= sida_pkg::ASCII_ZERO) &&
                      (o_char_code <= sida_pkg::ASCII_NINE))))
        else $error("output character is neither a digit nor a minus sign");

    // A minus sign is always followed by digits.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_code == sida_pkg::ASCII_MINUS)) |-> !o_last_char)
        else $error("minus sign marked as last character");

    // Once a word is taken the converter is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted twice in a row");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_char_code (o_char_code),
    .o_last_char (o_last_char)
);
